FILE: hdl/stb_pkg.sv
package stb_pkg;

  // default channel count
  localparam int STB_CHANNELS = 8;

  // register reset and counter limits
  localparam logic [15:0] TPS_RESET = 16'd990;
  localparam logic [30:0] RUN_WRAP  = 31'h7fffffff;
  localparam logic [30:0] RUN_LAST  = 31'h7ffffffe;
  localparam logic [5:0]  SEC_MAX   = 6'd59;
  localparam logic [5:0]  MIN_MAX   = 6'd59;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;

  // item kinds
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_CREATE = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_CHECK  = 3'd3;
  localparam logic [2:0] KIND_DELAY  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_ID = 2'd1;
  localparam logic [1:0] ST_IN_USE = 2'd2;
  localparam logic [1:0] ST_FREE   = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  timer_id;
    logic [31:0] period;
    logic        auto_reload;
    logic [15:0] delay_ms;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  expired_mask;
    logic        check_expired;
    logic        delay_done;
    logic [30:0] run_time;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic tick_start;
    logic exec_op;
    logic walk_step;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

  // one channel memory word
  typedef struct packed {
    logic [31:0] reload;
    logic [31:0] count;
  } chan_word_t;

endpackage

FILE: hdl/stb_ctrl.sv
module stb_ctrl
  import stb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  ctl,
  output logic       busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;

  // commands decoded from the current state
  always_comb begin
    ctl            = '0;
    ctl.latch      = (state == S_IDLE) && cmd_valid;
    ctl.tick_start = (state == S_EXEC) && stat.is_tick;
    ctl.exec_op    = (state == S_EXEC) && !stat.is_tick;
    ctl.walk_step  = (state == S_WALK);
    ctl.load_out   = (state == S_FINISH) && stat.out_free;
  end

  // state and registered stall
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= stat.is_tick ? S_WALK : S_FINISH;
        end
        S_WALK: begin
          if (stat.walk_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (stat.out_free) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !busy)
    else $error("stall raised while idle");

  a_latch_to_exec: assert property (@(posedge clk) disable iff (rst)
    ctl.latch |=> (state == S_EXEC) && busy)
    else $error("accepted item not executed");
`endif

endmodule

FILE: hdl/stb_datapath.sv
module stb_datapath
  import stb_pkg::*;
#(
  parameter int CHANNELS = STB_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        rsp_stall,
  output logic        rsp_valid,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  ctrl_cmd_t   ctl,
  output dp_stat_t    stat
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam logic [CNT_W-1:0] CNT_LIM  = CNT_W'(CHANNELS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);
  localparam logic [8:0]       ID_LIM   = 9'(CHANNELS);

  // configuration and latched item
  logic [15:0] tps;
  cmd_t        item;

  // per-channel bits
  logic [CHANNELS-1:0] chan_flag;
  logic [CHANNELS-1:0] chan_auto;
  logic [CHANNELS-1:0] chan_used;
  logic [CHANNELS-1:0] ent_ok;

  // channel count and reload store
  chan_word_t mem [CHANNELS];
  chan_word_t rd_word;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  chan_word_t       mem_wdata;
  logic             rd_issue;
  logic [IDX_W-1:0] mem_raddr;

  // walk pipeline
  logic [CNT_W-1:0] rd_idx;
  logic [IDX_W-1:0] wb_idx;
  logic             wb_valid;
  logic [31:0]      wb_count;
  logic [31:0]      wb_reload;
  logic [31:0]      wb_dec;
  logic             wb_live;
  logic             wb_hit;
  logic             wb_auto;

  // global counters
  logic [15:0] delay_left;
  logic        delay_flag;
  logic [30:0] tick_total;
  logic [15:0] sec_prescale;
  logic [5:0]  clock_sec;
  logic [5:0]  clock_min;
  logic [4:0]  clock_hour;
  logic [15:0] pre_inc;
  logic [15:0] limit;
  logic        sec_step;
  logic        min_step;
  logic        hour_step;

  // decode of management items
  logic             id_ok;
  logic [IDX_W-1:0] id_idx;
  logic [1:0]       ex_status;
  logic             ex_chk;
  logic             do_create;
  logic             do_delete;
  logic             do_delay;

  // result registers
  logic [1:0] res_status;
  logic       res_chk;
  logic [7:0] exp_mask;

  assign cfg_ready = 1'b1;

  // ticks per second register
  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_RESET;
    end else if (cfg_valid) begin
      tps <= cfg_data;
    end
  end

  // item register
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      item <= cmd;
    end
  end

  // management decode
  assign id_ok  = {1'b0, item.timer_id} < ID_LIM;
  assign id_idx = item.timer_id[IDX_W-1:0];

  always_comb begin
    ex_status = ST_OK;
    ex_chk    = 1'b0;
    do_create = 1'b0;
    do_delete = 1'b0;
    do_delay  = 1'b0;
    case (item.kind)
      KIND_CREATE: begin
        if (!id_ok) begin
          ex_status = ST_BAD_ID;
        end else if (chan_used[id_idx]) begin
          ex_status = ST_IN_USE;
        end else begin
          do_create = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (!id_ok) begin
          ex_status = ST_BAD_ID;
        end else if (!chan_used[id_idx]) begin
          ex_status = ST_FREE;
        end else begin
          do_delete = 1'b1;
        end
      end
      KIND_CHECK: begin
        if (!id_ok) begin
          ex_status = ST_BAD_ID;
        end else if (!chan_used[id_idx]) begin
          ex_status = ST_FREE;
        end else begin
          ex_chk = chan_flag[id_idx];
        end
      end
      KIND_DELAY: begin
        do_delay = (item.delay_ms != 16'd0);
      end
      default: begin
      end
    endcase
  end

  // countdown of the channel being written back
  always_comb begin
    wb_count  = ent_ok[wb_idx] ? rd_word.count : 32'd0;
    wb_reload = ent_ok[wb_idx] ? rd_word.reload : 32'd0;
    wb_dec    = wb_count - 32'd1;
    wb_auto   = chan_auto[wb_idx];
    wb_live   = ctl.walk_step && wb_valid && (wb_count != 32'd0);
    wb_hit    = wb_live && (wb_dec == 32'd0);
  end

  // memory port selection
  always_comb begin
    rd_issue  = ctl.tick_start || (ctl.walk_step && (rd_idx < CNT_LIM));
    mem_raddr = ctl.tick_start ? '0 : rd_idx[IDX_W-1:0];
    mem_we    = (ctl.exec_op && do_create) || wb_live;
    mem_waddr = ctl.exec_op ? id_idx : wb_idx;
    if (ctl.exec_op) begin
      mem_wdata.reload = item.period;
      mem_wdata.count  = item.period;
    end else begin
      mem_wdata.reload = wb_reload;
      mem_wdata.count  = (wb_hit && wb_auto) ? wb_reload : wb_dec;
    end
  end

  // channel store write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // channel store read port
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_word <= mem[mem_raddr];
    end
  end

  // walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      wb_idx   <= '0;
      wb_valid <= 1'b0;
    end else if (ctl.tick_start) begin
      rd_idx   <= CNT_W'(1);
      wb_idx   <= '0;
      wb_valid <= 1'b1;
    end else if (ctl.walk_step) begin
      if (rd_idx < CNT_LIM) begin
        rd_idx   <= rd_idx + CNT_W'(1);
        wb_idx   <= rd_idx[IDX_W-1:0];
        wb_valid <= 1'b1;
      end else begin
        wb_valid <= 1'b0;
      end
    end
  end

  // per-channel flag, mode, use and entry-valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_flag <= '0;
      chan_auto <= '0;
      chan_used <= '0;
      ent_ok    <= '0;
    end else begin
      if (ctl.exec_op && do_create) begin
        chan_flag[id_idx] <= 1'b0;
        chan_auto[id_idx] <= item.auto_reload;
        chan_used[id_idx] <= 1'b1;
        ent_ok[id_idx]    <= 1'b1;
      end
      if (ctl.exec_op && do_delete) begin
        chan_flag[id_idx] <= 1'b0;
        chan_auto[id_idx] <= 1'b0;
        chan_used[id_idx] <= 1'b0;
        ent_ok[id_idx]    <= 1'b0;
      end
      if (wb_hit) begin
        chan_flag[wb_idx] <= !wb_auto;
      end
    end
  end

  // seconds prescaler and clock carries
  always_comb begin
    pre_inc   = sec_prescale + 16'd1;
    limit     = (tps == 16'd0) ? 16'd1 : tps;
    sec_step  = (pre_inc >= limit);
    min_step  = sec_step && (clock_sec == SEC_MAX);
    hour_step = min_step && (clock_min == MIN_MAX);
  end

  // delay, run time and clock
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_left   <= '0;
      delay_flag   <= 1'b0;
      tick_total   <= '0;
      sec_prescale <= '0;
      clock_sec    <= '0;
      clock_min    <= '0;
      clock_hour   <= '0;
    end else if (ctl.tick_start) begin
      if (delay_left != 16'd0) begin
        delay_left <= delay_left - 16'd1;
        if (delay_left == 16'd1) begin
          delay_flag <= 1'b1;
        end
      end
      tick_total   <= (tick_total == RUN_LAST) ? 31'd0 : tick_total + 31'd1;
      sec_prescale <= sec_step ? 16'd0 : pre_inc;
      if (sec_step) begin
        clock_sec <= min_step ? 6'd0 : clock_sec + 6'd1;
      end
      if (min_step) begin
        clock_min <= hour_step ? 6'd0 : clock_min + 6'd1;
      end
      if (hour_step) begin
        clock_hour <= (clock_hour == HOUR_MAX) ? 5'd0 : clock_hour + 5'd1;
      end
    end else if (ctl.exec_op && do_delay) begin
      delay_left <= (item.delay_ms == 16'd1) ? 16'd2 : item.delay_ms;
      delay_flag <= 1'b0;
    end
  end

  // per-item result fields
  always_ff @(posedge clk) begin
    if (ctl.tick_start) begin
      res_status <= ST_OK;
      res_chk    <= 1'b0;
      exp_mask   <= '0;
    end else if (ctl.exec_op) begin
      res_status <= ex_status;
      res_chk    <= ex_chk;
      exp_mask   <= '0;
    end else if (wb_hit) begin
      exp_mask <= exp_mask | (8'd1 << wb_idx);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      rsp.status        <= res_status;
      rsp.expired_mask  <= exp_mask;
      rsp.check_expired <= res_chk;
      rsp.delay_done    <= delay_flag;
      rsp.run_time      <= tick_total;
      rsp.hours         <= clock_hour;
      rsp.minutes       <= clock_min;
      rsp.seconds       <= clock_sec;
    end
  end

  // status to the controller
  assign stat.is_tick   = (item.kind == KIND_TICK);
  assign stat.walk_done = wb_valid && (wb_idx == IDX_LAST);
  assign stat.out_free  = !rsp_valid || !rsp_stall;

`ifndef SYNTHESIS
  a_walk_ports_apart: assert property (@(posedge clk) disable iff (rst)
    (ctl.walk_step && wb_valid && rd_issue) |-> (wb_idx != rd_idx[IDX_W-1:0]))
    else $error("walk read and write hit the same channel");

  a_mask_only_tick: assert property (@(posedge clk) disable iff (rst)
    (ctl.load_out && !stat.is_tick) |-> (exp_mask == 8'd0))
    else $error("expiry mask set on a non-tick item");

  a_counters_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (clock_hour <= HOUR_MAX && clock_min <= MIN_MAX &&
                      clock_sec <= SEC_MAX && tick_total != RUN_WRAP))
    else $error("clock or run time out of range");
`endif

endmodule

FILE: hdl/soft_timer_bank_with_clock.sv
// tick item: walked over every channel, then loaded into the output register
// create, delete, check, delay items: executed, then loaded; cmd_stall is high until then
// a tick's length is set by the channel store walk, one read and one write per cycle
// a waiting result sits in the output register while the next item is accepted
// synchronous active-high reset clears all channels, counters and the clock at once;
// ticks_per_second returns to 990
module soft_timer_bank_with_clock
  import stb_pkg::*;
#(
  parameter int CHANNELS = STB_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;
  logic      busy;

  assign cmd_stall = busy;

  // sequencer
  stb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy)
  );

  // channel store, counters and output register
  stb_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import stb_pkg::*;

  // kinds the block ignores
  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

  localparam int CYCLE_LIMIT = 100_000;

  // idle styles shared by the sender and the receiver
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_FULL   = 1;
  localparam int IDLE_SPARSE = 2;

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_stall;
  cmd_t        cmd_item;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  soft_timer_bank_with_clock u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // directed stimulus row, with the obvious fields of the result written out
  typedef struct {
    cmd_t        c;
    bit          typed;
    logic [1:0]  status;
    logic [7:0]  mask;
    logic        chk;
  } stim_row_t;

  stim_row_t dir_rows[$];
  rsp_t      timer_results_due[$];

  // shadow of the timer bank
  logic [15:0] tps_reg;
  logic [31:0] ch_count  [STB_CHANNELS];
  logic [31:0] ch_reload [STB_CHANNELS];
  logic        ch_flag   [STB_CHANNELS];
  logic        ch_auto   [STB_CHANNELS];
  logic        ch_used   [STB_CHANNELS];
  logic [15:0] dly_left;
  logic        dly_flag;
  logic [30:0] run_cnt;
  logic [15:0] prescale;
  logic [5:0]  sec_cnt;
  logic [5:0]  min_cnt;
  logic [4:0]  hour_cnt;

  int idle_mode;
  int rsp_hold;
  int fail_cnt;
  int items_sent;
  int ticks_sent;
  int results_seen;
  int expiries_seen;
  int tps_writes;
  int cycle_count;

  task automatic clear_timer_model();
    tps_reg  = TPS_RESET;
    dly_left = '0;
    dly_flag = 1'b0;
    run_cnt  = '0;
    prescale = '0;
    sec_cnt  = '0;
    min_cnt  = '0;
    hour_cnt = '0;
    for (int i = 0; i < STB_CHANNELS; i++) begin
      ch_count[i]  = '0;
      ch_reload[i] = '0;
      ch_flag[i]   = 1'b0;
      ch_auto[i]   = 1'b0;
      ch_used[i]   = 1'b0;
    end
  endtask

  // apply one item to the shadow and return the result it should give
  function automatic rsp_t predict_timer_result(input cmd_t c);
    rsp_t        r;
    logic [15:0] sec_limit;
    logic [7:0]  fired;
    bit          id_ok;
    r = '0;
    fired = '0;
    id_ok = (c.timer_id < STB_CHANNELS);
    case (c.kind)
      KIND_TICK: begin
        // delay countdown
        if (dly_left != '0) begin
          dly_left = dly_left - 16'd1;
          if (dly_left == '0) dly_flag = 1'b1;
        end
        // run time, skipping the all-ones value
        run_cnt = run_cnt + 31'd1;
        if (run_cnt == RUN_WRAP) run_cnt = '0;
        // seconds prescaler and clock carries
        sec_limit = (tps_reg == '0) ? 16'd1 : tps_reg;
        prescale = prescale + 16'd1;
        if (prescale >= sec_limit) begin
          prescale = '0;
          sec_cnt = sec_cnt + 6'd1;
        end
        if (sec_cnt > SEC_MAX) begin
          sec_cnt = '0;
          min_cnt = min_cnt + 6'd1;
        end
        if (min_cnt > MIN_MAX) begin
          min_cnt = '0;
          hour_cnt = hour_cnt + 5'd1;
        end
        if (hour_cnt > HOUR_MAX) hour_cnt = '0;
        // channel countdown
        for (int i = 0; i < STB_CHANNELS; i++) begin
          if (ch_count[i] != '0) begin
            ch_count[i] = ch_count[i] - 32'd1;
            if (ch_count[i] == '0) begin
              if (ch_auto[i]) begin
                ch_count[i] = ch_reload[i];
                ch_flag[i]  = 1'b0;
              end else begin
                ch_flag[i] = 1'b1;
              end
              if (i < 8) fired[i] = 1'b1;
            end
          end
        end
        r.expired_mask = fired;
      end
      KIND_CREATE: begin
        if (!id_ok) begin
          r.status = ST_BAD_ID;
        end else if (ch_used[c.timer_id]) begin
          r.status = ST_IN_USE;
        end else begin
          ch_count[c.timer_id]  = c.period;
          ch_reload[c.timer_id] = c.period;
          ch_flag[c.timer_id]   = 1'b0;
          ch_auto[c.timer_id]   = c.auto_reload;
          ch_used[c.timer_id]   = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (!id_ok) begin
          r.status = ST_BAD_ID;
        end else if (!ch_used[c.timer_id]) begin
          r.status = ST_FREE;
        end else begin
          ch_count[c.timer_id]  = '0;
          ch_reload[c.timer_id] = '0;
          ch_flag[c.timer_id]   = 1'b0;
          ch_auto[c.timer_id]   = 1'b0;
          ch_used[c.timer_id]   = 1'b0;
        end
      end
      KIND_CHECK: begin
        if (!id_ok) r.status = ST_BAD_ID;
        else if (!ch_used[c.timer_id]) r.status = ST_FREE;
        else r.check_expired = ch_flag[c.timer_id];
      end
      KIND_DELAY: begin
        // zero is ignored, one is stretched to two
        if (c.delay_ms != '0) begin
          dly_left = (c.delay_ms == 16'd1) ? 16'd2 : c.delay_ms;
          dly_flag = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.delay_done = dly_flag;
    r.run_time   = run_cnt;
    r.hours      = hour_cnt;
    r.minutes    = min_cnt;
    r.seconds    = sec_cnt;
    return r;
  endfunction

  function automatic int draw_wait();
    case (idle_mode)
      IDLE_FULL:   return $urandom_range(0, 18);
      IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      default:     return 0;
    endcase
  endfunction

  // field by field comparison of one result
  task automatic compare_result(input rsp_t got, input rsp_t want);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_cnt++;
    end
    if (got.expired_mask !== want.expired_mask) begin
      $error("expired_mask: expected %02h, got %02h", want.expired_mask, got.expired_mask);
      fail_cnt++;
    end
    if (got.check_expired !== want.check_expired) begin
      $error("check_expired: expected %0d, got %0d", want.check_expired, got.check_expired);
      fail_cnt++;
    end
    if (got.delay_done !== want.delay_done) begin
      $error("delay_done: expected %0d, got %0d", want.delay_done, got.delay_done);
      fail_cnt++;
    end
    if (got.run_time !== want.run_time) begin
      $error("run_time: expected %0d, got %0d", want.run_time, got.run_time);
      fail_cnt++;
    end
    if (got.hours !== want.hours) begin
      $error("hours: expected %0d, got %0d", want.hours, got.hours);
      fail_cnt++;
    end
    if (got.minutes !== want.minutes) begin
      $error("minutes: expected %0d, got %0d", want.minutes, got.minutes);
      fail_cnt++;
    end
    if (got.seconds !== want.seconds) begin
      $error("seconds: expected %0d, got %0d", want.seconds, got.seconds);
      fail_cnt++;
    end
  endtask

  // result side: check each accepted item, then stall for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      rsp_hold = 0;
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (timer_results_due.size() == 0) begin
          $error("result with no item outstanding");
          fail_cnt++;
        end else begin
          compare_result(rsp_item, timer_results_due.pop_front());
        end
        if (rsp_item.expired_mask != '0) expiries_seen += $countones(rsp_item.expired_mask);
        rsp_hold = draw_wait();
      end
      if (rsp_hold > 0) begin
        rsp_stall <= 1'b1;
        rsp_hold--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // send one item; valid stays high when the next one follows without a gap
  task automatic send_item(input cmd_t c, input bit typed = 1'b0,
                           input logic [1:0] st = '0, input logic [7:0] m = '0,
                           input logic ck = 1'b0);
    int   gap;
    rsp_t want;
    gap = draw_wait();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    want = predict_timer_result(c);
    if (typed) begin
      want.status        = st;
      want.expired_mask  = m;
      want.check_expired = ck;
    end
    timer_results_due.push_back(want);
    items_sent++;
    if (c.kind == KIND_TICK) ticks_sent++;
  endtask

  // register write once every result is back and the walk has settled
  task automatic write_tps(input logic [15:0] v);
    cmd_valid <= 1'b0;
    while (timer_results_due.size() != 0) @(posedge clk);
    repeat (STB_CHANNELS + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tps_reg = v;
    tps_writes++;
  endtask

  task automatic add_row(input logic [2:0] k, input logic [7:0] id, input logic [31:0] per,
                         input logic ar, input logic [15:0] dms, input bit typed,
                         input logic [1:0] st = '0, input logic [7:0] m = '0,
                         input logic ck = 1'b0);
    stim_row_t row;
    row.c.kind        = k;
    row.c.timer_id    = id;
    row.c.period      = per;
    row.c.auto_reload = ar;
    row.c.delay_ms    = dms;
    row.typed         = typed;
    row.status        = st;
    row.mask          = m;
    row.chk           = ck;
    dir_rows.push_back(row);
  endtask

  // channel id: mostly one whose use state suits the item, sometimes out of range
  function automatic logic [7:0] pick_channel(input bit want_used);
    int start;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(STB_CHANNELS, 255));
    start = $urandom_range(0, STB_CHANNELS - 1);
    if ($urandom_range(0, 3) != 0) begin
      for (int k = 0; k < STB_CHANNELS; k++)
        if (ch_used[(start + k) % STB_CHANNELS] == want_used)
          return 8'((start + k) % STB_CHANNELS);
    end
    return 8'(start);
  endfunction

  // random item: all fields random, then the fields in use shaped
  function automatic cmd_t random_item();
    cmd_t c;
    int   pick;
    int   p;
    c.kind        = 3'($urandom);
    c.timer_id    = 8'($urandom);
    c.period      = $urandom;
    c.auto_reload = 1'($urandom);
    c.delay_ms    = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.kind = KIND_TICK;
    end else if (pick < 62) begin
      c.kind = KIND_CREATE;
      c.timer_id = pick_channel(1'b0);
      p = $urandom_range(0, 19);
      if (p < 12) c.period = $urandom_range(0, 12);
      else if (p < 17) c.period = $urandom_range(13, 400);
    end else if (pick < 75) begin
      c.kind = KIND_DELETE;
      c.timer_id = pick_channel(1'b1);
    end else if (pick < 89) begin
      c.kind = KIND_CHECK;
      c.timer_id = pick_channel(1'b1);
    end else if (pick < 95) begin
      c.kind = KIND_DELAY;
      p = $urandom_range(0, 9);
      if (p < 4) c.delay_ms = 16'($urandom_range(0, 3));
      else if (p < 8) c.delay_ms = 16'($urandom_range(4, 40));
    end else begin
      c.kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
    end
    return c;
  endfunction

  task automatic run_random(input int n, input int mode);
    idle_mode = mode;
    repeat (n) send_item(random_item());
  endtask

  // timeout
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // main sequence
  initial begin
    cmd_t c;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd_item  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_mode = IDLE_FULL;
    clear_timer_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table: error codes, one-shot and auto expiry, delay edge cases
    add_row(KIND_CHECK,  8'd0,   32'd0,        1'b0, 16'd0,      1, ST_FREE);
    add_row(KIND_DELETE, 8'd0,   32'd0,        1'b0, 16'd0,      1, ST_FREE);
    add_row(KIND_CREATE, 8'd8,   32'd5,        1'b0, 16'd0,      1, ST_BAD_ID);
    add_row(KIND_CREATE, 8'd255, 32'hffffffff, 1'b1, 16'hffff,   1, ST_BAD_ID);
    add_row(KIND_CHECK,  8'd200, 32'd0,        1'b0, 16'd0,      1, ST_BAD_ID);
    add_row(KIND_CREATE, 8'd0,   32'd1,        1'b0, 16'd0,      1, ST_OK);
    add_row(KIND_CREATE, 8'd0,   32'd7,        1'b1, 16'd0,      1, ST_IN_USE);
    add_row(KIND_TICK,   8'd0,   32'd0,        1'b0, 16'd0,      1, ST_OK, 8'h01);
    add_row(KIND_CHECK,  8'd0,   32'd0,        1'b0, 16'd0,      1, ST_OK, 8'h00, 1'b1);
    add_row(KIND_CREATE, 8'd7,   32'd2,        1'b1, 16'd0,      1, ST_OK);
    add_row(KIND_CREATE, 8'd1,   32'd0,        1'b1, 16'd0,      1, ST_OK);
    add_row(KIND_TICK,   8'd0,   32'd0,        1'b0, 16'd0,      1, ST_OK, 8'h00);
    add_row(KIND_TICK,   8'd0,   32'd0,        1'b0, 16'd0,      1, ST_OK, 8'h80);
    add_row(KIND_CHECK,  8'd7,   32'd0,        1'b0, 16'd0,      1, ST_OK);
    add_row(KIND_CHECK,  8'd1,   32'd0,        1'b0, 16'd0,      1, ST_OK);
    add_row(KIND_CREATE, 8'd2,   32'hffffffff, 1'b0, 16'd0,      1, ST_OK);
    add_row(KIND_DELETE, 8'd0,   32'd0,        1'b0, 16'd0,      1, ST_OK);
    add_row(KIND_CHECK,  8'd0,   32'd0,        1'b0, 16'd0,      1, ST_FREE);
    add_row(KIND_DELAY,  8'd0,   32'd0,        1'b0, 16'd0,      1, ST_OK);
    add_row(KIND_DELAY,  8'd0,   32'd0,        1'b0, 16'd1,      1, ST_OK);
    add_row(KIND_TICK,   8'hff,  32'hffffffff, 1'b1, 16'hffff,   0);
    add_row(KIND_TICK,   8'd0,   32'd0,        1'b0, 16'd0,      0);
    add_row(KIND_UNUSED_FIRST, 8'hff, 32'hffffffff, 1'b1, 16'hffff, 1, ST_OK);
    add_row(KIND_UNUSED_LAST,  8'd3,  32'd9,        1'b0, 16'd5,    0);
    add_row(KIND_DELAY,  8'd0,   32'd0,        1'b0, 16'hffff,   1, ST_OK);
    foreach (dir_rows[i])
      send_item(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].status, dir_rows[i].mask,
                dir_rows[i].chk);

    // random phases under several prescaler settings
    run_random(70, IDLE_FULL);
    // lowered below the running prescale count
    write_tps(16'd3);
    run_random(60, IDLE_SPARSE);
    // one tick per second: carry the seconds into the minutes
    write_tps(16'd1);
    idle_mode = IDLE_NONE;
    repeat (70) begin
      c = random_item();
      c.kind = KIND_TICK;
      send_item(c);
    end
    run_random(30, IDLE_SPARSE);
    // zero acts as one
    write_tps(16'd0);
    run_random(50, IDLE_FULL);
    write_tps(16'hffff);
    run_random(40, IDLE_NONE);
    write_tps(16'd7);
    run_random(50, IDLE_FULL);

    // drain
    cmd_valid <= 1'b0;
    while (timer_results_due.size() != 0) @(posedge clk);
    repeat (STB_CHANNELS + 8) @(posedge clk);

    $display("run: %0d items sent (%0d ticks), %0d results checked", items_sent, ticks_sent,
             results_seen);
    $display("run: %0d channel expiries seen, %0d prescaler writes, clock at %0d:%0d:%0d",
             expiries_seen, tps_writes, hour_cnt, min_cnt, sec_cnt);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
